@@ src/fdm_pkg.sv @@
package fdm_pkg;

  // Operand width used inside the block. The ports stay 64 bits wide; bits
  // above this width are ignored on input and are sign fill on output.
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned PORT_WIDTH = 64;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic  vld;
    word_t p;    // partial remainder
    word_t d;    // dividend bits still to go in, quotient bits coming out
    word_t ub;   // divisor magnitude
    logic  na;   // dividend negative
    logic  nb;   // divisor negative
    logic  dz;   // divisor zero
    logic  ov;   // minimum divided by minus one
  } div_stage_t;

  // Sign-extend a DATA_WIDTH value to the port width.
  function automatic logic [PORT_WIDTH-1:0] sext(input word_t v);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(v);
    return PORT_WIDTH'(s);
  endfunction

  // The most negative DATA_WIDTH number, sign-extended to the port width.
  localparam logic [PORT_WIDTH-1:0] MIN_EXT =
    PORT_WIDTH'(signed'({1'b1, {(DATA_WIDTH-1){1'b0}}}));

endpackage

@@ src/floor_divide_and_modulo.sv @@
// Channel | Direction | Handshake              | Payload
// in      | sink      | in_valid_i, in_stall_o | dividend_i, divisor_i
// out     | source    | out_valid_o, out_stall_i | quotient_o, remainder_o,
//         |           |                        | divide_by_zero_o, overflow_o
//
// One item is accepted every cycle while the output is not stalled. The operand
// magnitudes are formed in front of the entry register and captured at the
// accepting edge. Then comes one restoring step per quotient bit (one subtract
// and compare per stage), a register for the floor correction and one for the
// sign of the remainder, which is the output register.
// Reset clears only the valid bits of the stages; the data is not reset.
// When a result waits on a stalled output, the whole pipeline holds and the
// input is stalled in the same cycle, so no item is lost or repeated.
module floor_divide_and_modulo
  import fdm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [PORT_WIDTH-1:0] dividend_i,
  input  logic signed [PORT_WIDTH-1:0] divisor_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [PORT_WIDTH-1:0] quotient_o,
  output logic signed [PORT_WIDTH-1:0] remainder_o,
  output logic                         divide_by_zero_o,
  output logic                         overflow_o
);

  // The pipeline moves as one: it advances unless a result is held on the
  // output. Valid bits travel with the data, so bubbles simply pass through.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Entry stage: take the low DATA_WIDTH bits of each operand, record the
  // signs and the two special cases, and turn the operands into magnitudes.
  word_t      a, b;
  div_stage_t entry_d;
  always_comb begin
    a            = dividend_i[DATA_WIDTH-1:0];
    b            = divisor_i[DATA_WIDTH-1:0];
    entry_d.vld  = in_valid_i;
    entry_d.na   = a[DATA_WIDTH-1];
    entry_d.nb   = b[DATA_WIDTH-1];
    entry_d.p    = '0;
    entry_d.d    = a[DATA_WIDTH-1] ? word_t'(-a) : a;
    entry_d.ub   = b[DATA_WIDTH-1] ? word_t'(-b) : b;
    entry_d.dz   = (b == '0);
    // Minimum value over minus one. The quotient wraps on its own through the
    // normal path, so this only drives the flag.
    entry_d.ov   = (a == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (b == '1);
  end

  div_stage_t stg_q [DATA_WIDTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q[0].vld <= 1'b0;
    end else if (adv) begin
      stg_q[0] <= entry_d;
    end
  end

  // Restoring division, one quotient bit per stage. The dividend magnitude
  // shifts out of the top of d while the quotient bits shift into its bottom,
  // so after DATA_WIDTH stages d holds the quotient and p the remainder.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
    logic [DATA_WIDTH:0] t;
    logic [DATA_WIDTH:0] diff;
    logic                ge;
    div_stage_t          nxt;

    always_comb begin
      t    = {stg_q[k].p, stg_q[k].d[DATA_WIDTH-1]};
      diff = t - {1'b0, stg_q[k].ub};
      ge   = !diff[DATA_WIDTH];
      nxt   = stg_q[k];
      nxt.p = ge ? diff[DATA_WIDTH-1:0] : t[DATA_WIDTH-1:0];
      nxt.d = {stg_q[k].d[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[k+1].vld <= 1'b0;
      end else if (adv) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  // Floor correction. When the signs differ, the quotient is negated, and if
  // the division is not exact it moves one further from zero, -(q0 + 1) = ~q0,
  // and the remainder becomes divisor magnitude minus remainder.
  div_stage_t last;
  logic       differ, inexact;
  word_t      fq_d, fr_d;
  assign last = stg_q[DATA_WIDTH];

  always_comb begin
    differ  = last.na ^ last.nb;
    inexact = |last.p;
    if (!differ) begin
      fq_d = last.d;
    end else if (inexact) begin
      fq_d = ~last.d;
    end else begin
      fq_d = word_t'(-last.d);
    end
    fr_d = (differ && inexact) ? word_t'(last.ub - last.p) : last.p;
  end

  logic  fix_vld_q;
  word_t fix_q_q, fix_r_q;
  logic  fix_nb_q, fix_dz_q, fix_ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_vld_q <= 1'b0;
    end else if (adv) begin
      fix_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_q_q  <= fq_d;
      fix_r_q  <= fr_d;
      fix_nb_q <= last.nb;
      fix_dz_q <= last.dz;
      fix_ov_q <= last.ov;
    end
  end

  // Output stage: the remainder takes the sign of the divisor, and a zero
  // divisor forces both results to zero.
  word_t out_r;
  logic  out_vld_q;
  logic [PORT_WIDTH-1:0] quo_q, rem_q;
  logic  dz_q, ov_q;

  assign out_r = fix_nb_q ? word_t'(-fix_r_q) : fix_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quo_q <= fix_dz_q ? '0 : sext(fix_q_q);
      rem_q <= fix_dz_q ? '0 : sext(out_r);
      dz_q  <= fix_dz_q;
      ov_q  <= fix_ov_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign quotient_o       = signed'(quo_q);
  assign remainder_o      = signed'(rem_q);
  assign divide_by_zero_o = dz_q;
  assign overflow_o       = ov_q;

endmodule

@@ src/fdm_checker.sv @@
module fdm_checker
  import fdm_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [PORT_WIDTH-1:0] quotient_o,
  input logic signed [PORT_WIDTH-1:0] remainder_o,
  input logic                         divide_by_zero_o,
  input logic                         overflow_o
);

  // A result held on a stalled output stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quotient_o)
      && $stable(remainder_o))
    else $error("result changed while stalled");

  // The input is stalled only while a result waits on the output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // A zero divisor gives zero results and never the overflow flag.
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |->
      quotient_o == '0 && remainder_o == '0 && !overflow_o)
    else $error("bad divide by zero result");

  // Overflow wraps the quotient to the minimum value with no remainder.
  a_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      quotient_o == signed'(MIN_EXT) && remainder_o == '0)
    else $error("bad overflow result");

endmodule

bind floor_divide_and_modulo fdm_checker u_fdm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .quotient_o       (quotient_o),
  .remainder_o      (remainder_o),
  .divide_by_zero_o (divide_by_zero_o),
  .overflow_o       (overflow_o)
);

@@ dv/floor_divide_and_modulo_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the floored divide and modulo block. Every item
// accepted on the input channel gets its expected quotient, remainder and
// flags worked out here and queued. Every result taken from the output
// channel is checked field by field against the oldest entry in that queue.
module floor_divide_and_modulo_tb;
  import fdm_pkg::*;

  // One result as it leaves the block.
  typedef struct packed {
    logic signed [PORT_WIDTH-1:0] quotient;
    logic signed [PORT_WIDTH-1:0] remainder;
    logic                         by_zero;
    logic                         ovf;
  } divmod_result_t;

  // One row of the directed vectors. When fixed is set, the row carries its
  // expected result. Otherwise the predictor supplies it.
  typedef struct packed {
    logic [PORT_WIDTH-1:0] dividend;
    logic [PORT_WIDTH-1:0] divisor;
    logic                  fixed;
    divmod_result_t        want;
  } div_vector_t;

  // The most negative and most positive operands at the operand width,
  // sign-extended to the port width.
  localparam logic [PORT_WIDTH-1:0] WORD_MIN =
    {{(PORT_WIDTH - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [PORT_WIDTH-1:0] WORD_MAX = ~WORD_MIN;
  localparam logic [PORT_WIDTH-1:0] MINUS_ONE = '1;

  localparam divmod_result_t ZERO_DIVISOR_RESULT = '{'0, '0, 1'b1, 1'b0};
  localparam divmod_result_t MIN_BY_MINUS_ONE_RESULT = '{WORD_MIN, '0, 1'b0, 1'b1};

  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM   = 650;
  localparam int IDLE_PERCENT = 12;
  // Roughly 670 items, each slowed by sender gaps and receiver stalls at
  // a chance of IDLE_PERCENT each, plus the pipeline depth. This is many times
  // that.
  localparam int CYCLE_LIMIT  = 200000;

  logic                         clk_i;
  logic                         rst_ni           = 1'b0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic signed [PORT_WIDTH-1:0] dividend_i       = '0;
  logic signed [PORT_WIDTH-1:0] divisor_i        = '0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic signed [PORT_WIDTH-1:0] quotient_o;
  logic signed [PORT_WIDTH-1:0] remainder_o;
  logic                         divide_by_zero_o;
  logic                         overflow_o;

  divmod_result_t expected_results [$];
  bit             failed      = 1'b0;
  // Cleared during a quiet stretch of the random part, and for the drain at
  // the end, so that both channels then run back to back.
  bit             gaps_on     = 1'b1;
  int unsigned    cycle_count = 0;

  floor_divide_and_modulo i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o),
    .overflow_o      (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Floored division on the low DATA_WIDTH bits of each operand. The
  // division is done on magnitudes. When the signs differ and something is
  // left over, the quotient steps one further toward minus infinity and the
  // remainder is taken from the divisor's side. The remainder then takes the
  // sign of the divisor. A zero divisor only sets the by_zero flag.
  function automatic divmod_result_t floor_divmod(input logic [PORT_WIDTH-1:0] a_in,
                                                  input logic [PORT_WIDTH-1:0] b_in);
    word_t                        a, b, ua, ub, q0, r0, q, r;
    logic                         na, nb;
    logic signed [DATA_WIDTH-1:0] qs, rs;
    divmod_result_t               res;
    a   = a_in[DATA_WIDTH-1:0];
    b   = b_in[DATA_WIDTH-1:0];
    res = '0;
    if (b == '0) begin
      res.by_zero = 1'b1;
    end else begin
      na = a[DATA_WIDTH-1];
      nb = b[DATA_WIDTH-1];
      ua = na ? ('0 - a) : a;
      ub = nb ? ('0 - b) : b;
      q0 = ua / ub;
      r0 = ua % ub;
      if (na == nb) begin
        q = q0;
        r = r0;
      end else if (r0 == '0) begin
        q = '0 - q0;
        r = '0;
      end else begin
        q = ~q0;
        r = ub - r0;
      end
      if (nb) begin
        r = '0 - r;
      end
      // Only the most negative value over minus one overflows. The
      // quotient has already wrapped back to the most negative value.
      res.ovf       = (a == {1'b1, {(DATA_WIDTH - 1){1'b0}}}) && (b == '1);
      qs            = q;
      rs            = r;
      res.quotient  = qs;
      res.remainder = rs;
    end
    return res;
  endfunction

  // Operands for the random part. Full-width values alone almost never give
  // a quotient far from zero or one, so small values, values shifted down to a
  // random narrower width, extremes and 32-bit values are mixed in.
  function automatic logic [PORT_WIDTH-1:0] pick_operand();
    logic signed [PORT_WIDTH-1:0] v;
    int unsigned                  kind;
    kind = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (kind < 35) begin
      return v;
    end else if (kind < 55) begin
      v = $urandom_range(0, 40);
      return v - 20;
    end else if (kind < 67) begin
      case ($urandom_range(0, 6))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        3: return 64'd1;
        4: return MINUS_ONE;
        5: return WORD_MIN + 1;
        default: return WORD_MAX - 1;
      endcase
    end else if (kind < 85) begin
      return v >>> $urandom_range(1, 63);
    end else begin
      v = $signed($urandom);
      return v;
    end
  endfunction

  // Hands one item to the block. Random gaps come first while gaps_on is set.
  // After that, valid stays high with the payload held until the block takes
  // the item. A stall seen in the active region of the rising edge is the value
  // from before the edge, since the block updates its registers after that.
  task automatic send_pair(input logic [PORT_WIDTH-1:0] a,
                           input logic [PORT_WIDTH-1:0] b,
                           input logic                  fixed,
                           input divmod_result_t        fixed_result);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dividend_i <= a;
    divisor_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    expected_results.push_back(fixed ? fixed_result : floor_divmod(a, b));
    @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input logic signed [PORT_WIDTH-1:0] want,
                              input logic signed [PORT_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // The receiving side stalls the output at random, except in reset, in the quiet
  // stretch and in the drain.
  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && rst_ni && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin : result_check
    divmod_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{quotient_o, remainder_o, divide_by_zero_o, overflow_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got q=%0d r=%0d dz=%b ov=%b",
                 $time, got.quotient, got.remainder, got.by_zero, got.ovf);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        report_field("quotient", want.quotient, got.quotient);
        report_field("remainder", want.remainder, got.remainder);
        report_field("divide_by_zero", PORT_WIDTH'(want.by_zero),
                     PORT_WIDTH'(got.by_zero));
        report_field("overflow", PORT_WIDTH'(want.ovf), PORT_WIDTH'(got.ovf));
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("floor_divide_and_modulo_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    // The directed vectors cover the sign combinations, inexact and exact
    // division, both flagged cases, and the extremes against each other.
    div_vector_t directed_vectors [NUM_DIRECTED] = '{
      '{64'sd7,     64'sd0,    1'b1, ZERO_DIVISOR_RESULT},
      '{WORD_MIN,   64'sd0,    1'b1, ZERO_DIVISOR_RESULT},
      '{64'sd0,     64'sd0,    1'b1, ZERO_DIVISOR_RESULT},
      '{WORD_MAX,   64'sd0,    1'b1, ZERO_DIVISOR_RESULT},
      '{WORD_MIN,   MINUS_ONE, 1'b1, MIN_BY_MINUS_ONE_RESULT},
      '{64'sd7,     64'sd2,    1'b0, '0},
      '{-64'sd7,    64'sd2,    1'b0, '0},
      '{64'sd7,     -64'sd2,   1'b0, '0},
      '{-64'sd7,    -64'sd2,   1'b0, '0},
      '{-64'sd6,    64'sd3,    1'b0, '0},
      '{64'sd6,     -64'sd3,   1'b0, '0},
      '{WORD_MAX,   64'sd1,    1'b1, '{WORD_MAX, '0, 1'b0, 1'b0}},
      '{WORD_MIN,   64'sd1,    1'b1, '{WORD_MIN, '0, 1'b0, 1'b0}},
      '{WORD_MAX,   MINUS_ONE, 1'b1, '{WORD_MIN + 1, '0, 1'b0, 1'b0}},
      '{WORD_MIN,   WORD_MIN,  1'b1, '{64'sd1, '0, 1'b0, 1'b0}},
      '{WORD_MIN,   WORD_MAX,  1'b0, '0},
      '{WORD_MAX,   WORD_MIN,  1'b0, '0},
      '{MINUS_ONE,  WORD_MAX,  1'b0, '0},
      '{64'sd1,     WORD_MIN,  1'b0, '0},
      '{64'sd0,     -64'sd5,   1'b1, '{'0, '0, 1'b0, 1'b0}},
      '{MINUS_ONE,  MINUS_ONE, 1'b1, '{64'sd1, '0, 1'b0, 1'b0}}
    };
    logic [PORT_WIDTH-1:0] a, b;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_vectors[i]) begin
      send_pair(directed_vectors[i].dividend, directed_vectors[i].divisor,
                directed_vectors[i].fixed, directed_vectors[i].want);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // A stretch in the middle runs with no gaps on either side.
      gaps_on = !(i >= 250 && i < 400);
      if ($urandom_range(0, 99) < 3) begin
        a = WORD_MIN;
        b = MINUS_ONE;
      end else begin
        a = pick_operand();
        b = pick_operand();
      end
      send_pair(a, b, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain with the output never stalled, then allow one more pipeline
    // depth so that any stray result still shows up.
    gaps_on = 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DATA_WIDTH + 10) @(posedge clk_i);

    if (!failed) begin
      $display("floor_divide_and_modulo_tb: PASS");
    end else begin
      $display("floor_divide_and_modulo_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fdm_pkg.sv
src/floor_divide_and_modulo.sv
src/fdm_checker.sv
dv/floor_divide_and_modulo_tb.sv
